>>> sv/retry_backoff_governor_macros.svh
// Assertion macros used by the retry backoff governor top level.
`ifndef RETRY_BACKOFF_GOVERNOR_MACROS_SVH
`define RETRY_BACKOFF_GOVERNOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RBG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbg: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define RBG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbg: next-cycle check failed");

`endif

>>> sv/rbg_pkg.sv
// Shared types and constants for the retry backoff governor.
`default_nettype none
package rbg_pkg;

  localparam int TIME_W  = 48;
  localparam int VAL_W   = 32;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 3;

  // Operating modes; the unused code behaves as persist
  localparam logic [MODE_W-1:0] MODE_PERSIST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACKOFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOUNDED = 2'd2;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [INDEX_W-1:0] REG_ATTEMPT_LIMIT  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_QUIET_TIME     = 3'd2;
  localparam logic [INDEX_W-1:0] REG_RESUME_DELAY   = 3'd3;
  localparam logic [INDEX_W-1:0] REG_INITIAL_WINDOW = 3'd4;
  localparam logic [INDEX_W-1:0] REG_MAX_WINDOW     = 3'd5;

  // Reset values of the configuration registers
  localparam logic [MODE_W-1:0] RST_MODE           = MODE_PERSIST;
  localparam logic [VAL_W-1:0]  RST_ATTEMPT_LIMIT  = 32'd5;
  localparam logic [VAL_W-1:0]  RST_QUIET_TIME     = 32'd60000;
  localparam logic [VAL_W-1:0]  RST_RESUME_DELAY   = 32'd0;
  localparam logic [VAL_W-1:0]  RST_INITIAL_WINDOW = 32'd1000;
  localparam logic [VAL_W-1:0]  RST_MAX_WINDOW     = 32'd60000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  attempt_limit;
    logic [VAL_W-1:0]  quiet_time_ms;
    logic [VAL_W-1:0]  resume_delay_ms;
    logic [VAL_W-1:0]  initial_window_ms;
    logic [VAL_W-1:0]  max_window_ms;
  } cfg_t;

  typedef struct packed {
    logic             repair_now;
    logic             wake_valid;
    logic [VAL_W-1:0] wake_delay_ms;
    logic             gave_up;
  } res_t;

endpackage
`default_nettype wire

>>> sv/rbg_cfg_regs.sv
// Configuration register file of the retry backoff governor.
`default_nettype none
module rbg_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [rbg_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [rbg_pkg::VAL_W-1:0]    cfg_data,
  output rbg_pkg::cfg_t                     cfg
);
  import rbg_pkg::*;

  // Indexed writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= RST_MODE;
      cfg.attempt_limit     <= RST_ATTEMPT_LIMIT;
      cfg.quiet_time_ms     <= RST_QUIET_TIME;
      cfg.resume_delay_ms   <= RST_RESUME_DELAY;
      cfg.initial_window_ms <= RST_INITIAL_WINDOW;
      cfg.max_window_ms     <= RST_MAX_WINDOW;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:           cfg.mode              <= cfg_data[MODE_W-1:0];
        REG_ATTEMPT_LIMIT:  cfg.attempt_limit     <= cfg_data;
        REG_QUIET_TIME:     cfg.quiet_time_ms     <= cfg_data;
        REG_RESUME_DELAY:   cfg.resume_delay_ms   <= cfg_data;
        REG_INITIAL_WINDOW: cfg.initial_window_ms <= cfg_data;
        REG_MAX_WINDOW:     cfg.max_window_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/rbg_engine.sv
// Decision logic and retry state of the retry backoff governor.
`default_nettype none
module rbg_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire logic [rbg_pkg::TIME_W-1:0] now,
  input  rbg_pkg::cfg_t                   cfg,
  output rbg_pkg::res_t                   res
);
  import rbg_pkg::*;

  localparam logic [VAL_W-1:0] CNT_FULL = '1;

  logic               seen_drift, seen_drift_next;
  logic [TIME_W-1:0]  prev_drift_time, prev_drift_time_next;
  logic [VAL_W-1:0]   backoff_window, backoff_window_next;
  logic               seen_repair, seen_repair_next;
  logic [TIME_W-1:0]  prev_repair_time, prev_repair_time_next;
  logic               given_up_flag, given_up_flag_next;
  logic [TIME_W-1:0]  give_up_time, give_up_time_next;
  logic [VAL_W-1:0]   attempt_count, attempt_count_next;

  logic [TIME_W-1:0]  drift_gap;
  logic [TIME_W-1:0]  repair_gap;
  logic [TIME_W-1:0]  cool_gap;
  logic               quiet;
  logic [VAL_W-1:0]   win;
  logic               rep_seen;
  logic [VAL_W-1:0]   cnt;
  logic               proceed;

  // Wrapping time differences
  assign drift_gap  = now - prev_drift_time;
  assign repair_gap = now - prev_repair_time;
  assign cool_gap   = now - give_up_time;
  assign quiet = seen_drift &&
                 (drift_gap >= {{(TIME_W-VAL_W){1'b0}}, cfg.quiet_time_ms});

  // Per-mode decision and next state
  always_comb begin
    seen_drift_next       = 1'b1;
    prev_drift_time_next  = now;
    backoff_window_next   = backoff_window;
    seen_repair_next      = seen_repair;
    prev_repair_time_next = prev_repair_time;
    given_up_flag_next    = given_up_flag;
    give_up_time_next     = give_up_time;
    attempt_count_next    = attempt_count;
    res                   = '{repair_now: 1'b1, wake_valid: 1'b0,
                              wake_delay_ms: '0, gave_up: 1'b0};
    win      = quiet ? '0 : backoff_window;
    rep_seen = quiet ? 1'b0 : seen_repair;
    cnt      = attempt_count;
    proceed  = 1'b1;

    case (cfg.mode)
      MODE_BACKOFF: begin
        backoff_window_next = win;
        seen_repair_next    = rep_seen;
        if (!rep_seen || (repair_gap >= {{(TIME_W-VAL_W){1'b0}}, win})) begin
          // Window elapsed: repair and widen the window
          prev_repair_time_next = now;
          seen_repair_next      = 1'b1;
          if (win == '0) begin
            backoff_window_next = cfg.initial_window_ms;
          end else if (win > (cfg.max_window_ms >> 1)) begin
            backoff_window_next = cfg.max_window_ms;
          end else begin
            backoff_window_next = win << 1;
          end
        end else begin
          // Still inside the window: wake when it closes
          res.repair_now    = 1'b0;
          res.wake_valid    = 1'b1;
          res.wake_delay_ms = win - repair_gap[VAL_W-1:0];
        end
      end
      MODE_BOUNDED: begin
        if (given_up_flag) begin
          if (cfg.resume_delay_ms == '0) begin
            res     = '{repair_now: 1'b0, wake_valid: 1'b0,
                        wake_delay_ms: '0, gave_up: 1'b1};
            proceed = 1'b0;
          end else if (cool_gap < {{(TIME_W-VAL_W){1'b0}}, cfg.resume_delay_ms}) begin
            res     = '{repair_now: 1'b0, wake_valid: 1'b1,
                        wake_delay_ms: cfg.resume_delay_ms - cool_gap[VAL_W-1:0],
                        gave_up: 1'b1};
            proceed = 1'b0;
          end else begin
            given_up_flag_next = 1'b0;
            cnt                = '0;
          end
        end
        if (proceed) begin
          if (quiet) begin
            cnt = '0;
          end
          if (cnt != CNT_FULL) begin
            cnt = cnt + 1'b1;
          end
          attempt_count_next = cnt;
          if ((cfg.attempt_limit != '0) && (cnt > cfg.attempt_limit)) begin
            // Over the limit: enter the given-up state
            given_up_flag_next = 1'b1;
            give_up_time_next  = now;
            res.repair_now     = 1'b0;
            res.wake_valid     = (cfg.resume_delay_ms != '0);
            res.wake_delay_ms  = cfg.resume_delay_ms;
            res.gave_up        = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // State update on each item that moves to the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_drift       <= 1'b0;
      prev_drift_time  <= '0;
      backoff_window   <= '0;
      seen_repair      <= 1'b0;
      prev_repair_time <= '0;
      given_up_flag    <= 1'b0;
      give_up_time     <= '0;
      attempt_count    <= '0;
    end else if (fire) begin
      seen_drift       <= seen_drift_next;
      prev_drift_time  <= prev_drift_time_next;
      backoff_window   <= backoff_window_next;
      seen_repair      <= seen_repair_next;
      prev_repair_time <= prev_repair_time_next;
      given_up_flag    <= given_up_flag_next;
      give_up_time     <= give_up_time_next;
      attempt_count    <= attempt_count_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/retry_backoff_governor.sv
// Top level of the retry backoff governor: input register, engine, result register.
// Each drift item is captured in an input register, decided by the engine against
// the retry state once the result register can take it, and lands in that register;
// one item per cycle is sustained while the output is not stalled. The input side
// stalls only when the input register holds an item and the result register is full
// and stalled. Configuration is a write-only port indexed 0..5 (mode, attempt limit,
// quiet time, resume delay, initial window, max window); write it only while idle.
`default_nettype none
module retry_backoff_governor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rbg_pkg::TIME_W-1:0]  event_time_ms,
  input  wire logic                        cfg_write,
  input  wire logic [rbg_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [rbg_pkg::VAL_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             repair_now,
  output logic                             wake_valid,
  output logic [rbg_pkg::VAL_W-1:0]        wake_delay_ms,
  output logic                             gave_up
);
  import rbg_pkg::*;
  `include "retry_backoff_governor_macros.svh"

  cfg_t              cfg;
  res_t              res;
  logic              in_held;
  logic [TIME_W-1:0] in_time;
  logic              fire;

  rbg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbg_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .now  (in_time),
    .cfg  (cfg),
    .res  (res)
  );

  // Handshake between the two stages
  assign fire     = in_held && !(out_valid && out_stall);
  assign in_stall = in_held && out_valid && out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_held <= 1'b1;
    end else if (fire) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_time <= event_time_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      repair_now    <= res.repair_now;
      wake_valid    <= res.wake_valid;
      wake_delay_ms <= res.wake_valid ? res.wake_delay_ms : '0;
      gave_up       <= res.gave_up;
    end
  end

  // Checks
  `RBG_ASSERT_NOW(a_repair_no_wake, out_valid && repair_now, !wake_valid && !gave_up)
  `RBG_ASSERT_NOW(a_delay_zero_idle, out_valid && !wake_valid, wake_delay_ms == '0)
  `RBG_ASSERT_NOW(a_stall_needs_item, in_stall, in_held && out_valid)
  `RBG_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)
  `RBG_ASSERT_NOW(a_wake_needs_cause, out_valid && wake_valid, !repair_now)

endmodule
`default_nettype wire
